// File: rtl/ascon128_aead_encrypt_core_assert.svh
// Assertion macros for the ASCON-128 encryption core.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef ASCON128_AEAD_ENCRYPT_CORE_ASSERT_SVH
`define ASCON128_AEAD_ENCRYPT_CORE_ASSERT_SVH

`define ASCON_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ascon core assertion failed");

`define ASCON_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ascon core assertion failed");

`endif

// File: rtl/ascon_pkg.sv
// Shared types, constants and helper functions of the ASCON-128 encryption core.
// No dependencies.
package ascon_pkg;

  typedef logic [4:0][63:0] ascon_word5_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } ascon_key_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PERM,
    ST_PAD,
    ST_TAG1,
    ST_TAG2
  } ascon_fsm_e;

  typedef enum logic [1:0] {
    POST_INIT,
    POST_BLOCK,
    POST_PAD,
    POST_TAG
  } ascon_post_e;

  localparam logic [63:0] AsconIv      = 64'h80400c0600000000;
  localparam logic [63:0] PadFullBlock = 64'h8000000000000000;
  localparam logic [63:0] DomainSep    = 64'h0000000000000001;
  localparam logic [3:0]  RndFullStart = 4'd0;
  localparam logic [3:0]  RndHalfStart = 4'd6;
  localparam logic [3:0]  RndLast      = 4'd11;
  localparam logic [3:0]  BytesFull    = 4'd8;

  localparam logic [1:0] KindCt   = 2'd0;
  localparam logic [1:0] KindTag1 = 2'd1;
  localparam logic [1:0] KindTag2 = 2'd2;

  localparam logic FuncStart = 1'b0;

  function automatic logic [7:0] ascon_rc(input logic [3:0] idx);
    logic [7:0] rc;
    case (idx)
      4'd0:    rc = 8'hf0;
      4'd1:    rc = 8'he1;
      4'd2:    rc = 8'hd2;
      4'd3:    rc = 8'hc3;
      4'd4:    rc = 8'hb4;
      4'd5:    rc = 8'ha5;
      4'd6:    rc = 8'h96;
      4'd7:    rc = 8'h87;
      4'd8:    rc = 8'h78;
      4'd9:    rc = 8'h69;
      4'd10:   rc = 8'h5a;
      4'd11:   rc = 8'h4b;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

  function automatic logic [63:0] byte_mask(input logic [2:0] n);
    return ~(64'hFFFFFFFFFFFFFFFF >> {n, 3'b000});
  endfunction

  function automatic logic [63:0] pad_word(input logic [2:0] n);
    return PadFullBlock >> {n, 3'b000};
  endfunction

endpackage

// File: rtl/ascon_round.sv
// One round of the ASCON permutation: constant addition, S-box layer and linear layer.
// Depends on ascon_pkg.
module ascon_perm_round
  import ascon_pkg::*;
(
  input  ascon_word5_t state_i,
  input  logic [7:0]   rc_i,
  output ascon_word5_t state_o
);

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  logic [63:0] a0, a1, a2, a3, a4;
  logic [63:0] t0, t1, t2, t3, t4;
  logic [63:0] b0, b1, b2, b3, b4;
  logic [63:0] c0, c1, c2, c3, c4;

  always_comb begin
    a2 = state_i[2] ^ {56'd0, rc_i} ^ state_i[1];
    a0 = state_i[0] ^ state_i[4];
    a4 = state_i[4] ^ state_i[3];
    a1 = state_i[1];
    a3 = state_i[3];
    t0 = ~a0 & a1;
    t1 = ~a1 & a2;
    t2 = ~a2 & a3;
    t3 = ~a3 & a4;
    t4 = ~a4 & a0;
    b0 = a0 ^ t1;
    b1 = a1 ^ t2;
    b2 = a2 ^ t3;
    b3 = a3 ^ t4;
    b4 = a4 ^ t0;
    c1 = b1 ^ b0;
    c0 = b0 ^ b4;
    c3 = b3 ^ b2;
    c2 = ~b2;
    c4 = b4;
    state_o[0] = c0 ^ rotr(c0, 19) ^ rotr(c0, 28);
    state_o[1] = c1 ^ rotr(c1, 61) ^ rotr(c1, 39);
    state_o[2] = c2 ^ rotr(c2, 1) ^ rotr(c2, 6);
    state_o[3] = c3 ^ rotr(c3, 10) ^ rotr(c3, 17);
    state_o[4] = c4 ^ rotr(c4, 7) ^ rotr(c4, 41);
  end

endmodule

// File: rtl/ascon_regs.sv
// Key register file behind the APB configuration port.
// Depends on ascon_pkg.
module ascon_regs
  import ascon_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [3:0]  paddr_i,
  input  logic [63:0] pwdata_i,
  output logic [63:0] prdata_o,
  output logic        pready_o,
  output ascon_key_t  key_o
);

  ascon_key_t key_q, key_d;
  logic       wr_en;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i;

  always_comb begin
    key_d = key_q;
    if (wr_en) begin
      if (paddr_i[3]) begin
        key_d.lo = pwdata_i;
      end else begin
        key_d.hi = pwdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign prdata_o = paddr_i[3] ? key_q.lo : key_q.hi;
  assign key_o    = key_q;

endmodule

// File: rtl/ascon128_aead_encrypt_core.sv
// ASCON-128 authenticated encryption core with empty associated data.
// Depends on ascon_pkg, ascon_regs, ascon_perm_round and the assertion macro header.
//
// The key is written over the APB port (key_high at 0x0, key_low at 0x8); the user must
// write it only while the core is idle, which the core does not enforce. Input words
// arrive on the s_axis channel: tuser 0 starts a message with the nonce in tdata, tuser 1
// carries up to eight plaintext bytes, and tlast marks the final block. Results leave on
// the m_axis channel: ciphertext words, then the two tag halves, the second one with tlast set.
// One permutation round is computed per cycle by a single shared round unit.
// A start word and a final block with fewer than eight bytes run the full permutation, a
// non-final block the half one; a final block of eight bytes adds a padding block to it.
// A data word that arrives while no message is open is dropped without a result.
// Results are held in one output register; while the receiver stalls, the core
// waits before loading the next result and does not take new input words.
// Reset clears the key, closes any open message and drops a pending result.
module ascon128_aead_encrypt_core
  import ascon_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel_i,
  input  logic         penable_i,
  input  logic         pwrite_i,
  input  logic [3:0]   paddr_i,
  input  logic [63:0]  pwdata_i,
  output logic [63:0]  prdata_o,
  output logic         pready_o,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // nonce_high, nonce_low, block_data, block_bytes, zero fill
  input  logic [199:0] s_axis_tdata_i,
  // func
  input  logic         s_axis_tuser_i,
  // final_block
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // out_data, out_bytes, zero fill
  output logic [71:0]  m_axis_tdata_o,
  // out_kind
  output logic [1:0]   m_axis_tuser_o,
  // out_last
  output logic         m_axis_tlast_o
);

  ascon_key_t   key;
  ascon_word5_t s_q, s_d, round_out;
  ascon_fsm_e   fsm_q, fsm_d;
  ascon_post_e  post_q, post_d;
  logic [3:0]   rnd_q, rnd_d;
  logic         open_q, open_d;
  logic         out_vld_q, out_vld_d;
  logic [63:0]  out_data_q, out_data_d;
  logic [3:0]   out_bytes_q, out_bytes_d;
  logic [1:0]   out_kind_q, out_kind_d;
  logic         out_last_q, out_last_d;
  logic         out_load, out_free, in_acc, rnd_end;

  logic [63:0]  in_nonce_hi, in_nonce_lo, in_data;
  logic [3:0]   in_bytes, nbytes;
  logic         blk_full;
  logic [63:0]  fin_mask, fin_pad;

  ascon_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .key_o     (key)
  );

  ascon_perm_round u_round (
    .state_i (s_q),
    .rc_i    (ascon_rc(rnd_q)),
    .state_o (round_out)
  );

  assign in_nonce_hi = s_axis_tdata_i[63:0];
  assign in_nonce_lo = s_axis_tdata_i[127:64];
  assign in_data     = s_axis_tdata_i[191:128];
  assign in_bytes    = s_axis_tdata_i[195:192];
  assign nbytes      = in_bytes[3] ? BytesFull : in_bytes;
  assign blk_full    = !s_axis_tlast_i || in_bytes[3];
  assign fin_mask    = byte_mask(nbytes[2:0]);
  assign fin_pad     = pad_word(nbytes[2:0]);

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = (fsm_q == ST_IDLE) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign rnd_end         = (rnd_q == RndLast);

  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      ST_IDLE: begin
        if (in_acc && (s_axis_tuser_i == FuncStart || open_q)) begin
          fsm_d = ST_PERM;
        end
      end
      ST_PERM: begin
        if (rnd_end) begin
          case (post_q)
            POST_PAD: fsm_d = ST_PAD;
            POST_TAG: fsm_d = ST_TAG1;
            default:  fsm_d = ST_IDLE;
          endcase
        end
      end
      ST_PAD:  if (out_free) fsm_d = ST_PERM;
      ST_TAG1: if (out_free) fsm_d = ST_TAG2;
      ST_TAG2: if (out_free) fsm_d = ST_IDLE;
      default: fsm_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_d         = s_q;
    rnd_d       = rnd_q;
    post_d      = post_q;
    open_d      = open_q;
    out_load    = 1'b0;
    out_data_d  = out_data_q;
    out_bytes_d = out_bytes_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    case (fsm_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i == FuncStart) begin
            s_d[0] = AsconIv;
            s_d[1] = key.hi;
            s_d[2] = key.lo;
            s_d[3] = in_nonce_hi;
            s_d[4] = in_nonce_lo;
            rnd_d  = RndFullStart;
            post_d = POST_INIT;
            open_d = 1'b1;
          end else if (open_q) begin
            out_load   = 1'b1;
            out_kind_d = KindCt;
            out_last_d = 1'b0;
            if (blk_full) begin
              s_d[0]      = s_q[0] ^ in_data;
              out_data_d  = s_q[0] ^ in_data;
              out_bytes_d = BytesFull;
              rnd_d       = RndHalfStart;
              post_d      = s_axis_tlast_i ? POST_PAD : POST_BLOCK;
            end else begin
              s_d[0]      = s_q[0] ^ (in_data & fin_mask) ^ fin_pad;
              s_d[1]      = s_q[1] ^ key.hi;
              s_d[2]      = s_q[2] ^ key.lo;
              out_data_d  = (s_q[0] ^ in_data) & fin_mask;
              out_bytes_d = nbytes;
              rnd_d       = RndFullStart;
              post_d      = POST_TAG;
            end
            if (s_axis_tlast_i) begin
              open_d = 1'b0;
            end
          end
        end
      end
      ST_PERM: begin
        s_d   = round_out;
        rnd_d = rnd_q + 4'd1;
        if (rnd_end && post_q == POST_INIT) begin
          s_d[3] = round_out[3] ^ key.hi;
          s_d[4] = round_out[4] ^ key.lo ^ DomainSep;
        end
      end
      ST_PAD: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_data_d  = '0;
          out_bytes_d = '0;
          out_kind_d  = KindCt;
          out_last_d  = 1'b0;
          s_d[0]      = s_q[0] ^ PadFullBlock;
          s_d[1]      = s_q[1] ^ key.hi;
          s_d[2]      = s_q[2] ^ key.lo;
          rnd_d       = RndFullStart;
          post_d      = POST_TAG;
        end
      end
      ST_TAG1: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_data_d  = s_q[3] ^ key.hi;
          out_bytes_d = BytesFull;
          out_kind_d  = KindTag1;
          out_last_d  = 1'b0;
        end
      end
      ST_TAG2: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_data_d  = s_q[4] ^ key.lo;
          out_bytes_d = BytesFull;
          out_kind_d  = KindTag2;
          out_last_d  = 1'b1;
        end
      end
      default: begin
        s_d = s_q;
      end
    endcase
    out_vld_d = out_load || (out_vld_q && !m_axis_tready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q     <= ST_IDLE;
      post_q    <= POST_INIT;
      rnd_q     <= RndFullStart;
      open_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      fsm_q     <= fsm_d;
      post_q    <= post_d;
      rnd_q     <= rnd_d;
      open_q    <= open_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q         <= s_d;
    out_data_q  <= out_data_d;
    out_bytes_q <= out_bytes_d;
    out_kind_q  <= out_kind_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {4'd0, out_bytes_q, out_data_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

`include "ascon128_aead_encrypt_core_assert.svh"

  `ASCON_ASSERT_IMP(a_rnd_range, fsm_q == ST_PERM, rnd_q <= RndLast)
  `ASCON_ASSERT_NXT(a_perm_holds, fsm_q == ST_PERM && !rnd_end, fsm_q == ST_PERM)
  `ASCON_ASSERT_NXT(a_block_out, in_acc && s_axis_tuser_i && open_q,
                    m_axis_tvalid_o && m_axis_tuser_o == KindCt)
  `ASCON_ASSERT_IMP(a_last_tag2, m_axis_tvalid_o && m_axis_tlast_o,
                    m_axis_tuser_o == KindTag2)
  `ASCON_ASSERT_NXT(a_tag1_follows, fsm_q == ST_PERM && rnd_end && post_q == POST_TAG,
                    fsm_q == ST_TAG1 && !open_q)

endmodule
